// ===== design/lsta_pkg.sv =====
// Shared types, constants and register codes of the line sensor trend analyzer.
package lsta_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int SENSOR_COUNT = 8;
    localparam int SIDE_COUNT   = 4;
    localparam int WIDE_MIN     = 3;
    localparam int CROSS_MIN    = 7;

    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_BLACK_THRESHOLD    = 3'd0;
    localparam logic [2:0] REG_TREND_MIN_COUNT    = 3'd1;
    localparam logic [2:0] REG_CENTER_LEFT_INDEX  = 3'd2;
    localparam logic [2:0] REG_CENTER_RIGHT_INDEX = 3'd3;
    localparam logic [2:0] REG_SPECIAL_MIN_COUNT  = 3'd4;

    typedef enum logic [1:0] {
        TREND_NONE  = 2'd0,
        TREND_LEFT  = 2'd1,
        TREND_RIGHT = 2'd2
    } t_trend;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_0;
        logic [SAMPLE_BITS-1:0] sample_1;
        logic [SAMPLE_BITS-1:0] sample_2;
        logic [SAMPLE_BITS-1:0] sample_3;
        logic [SAMPLE_BITS-1:0] sample_4;
        logic [SAMPLE_BITS-1:0] sample_5;
        logic [SAMPLE_BITS-1:0] sample_6;
        logic [SAMPLE_BITS-1:0] sample_7;
    } t_in_word;

    typedef struct packed {
        logic [3:0] black_total;
        logic [2:0] black_left;
        logic [2:0] black_right;
        logic [2:0] larger_side;
        logic       all_white;
        logic       center_line;
        logic       wide_line;
        logic       crossing;
        logic       special_eval;
        logic [1:0] trend_before_eval;
        logic [1:0] trend_now;
        logic [1:0] trend_prior;
    } t_out_word;

    typedef struct packed {
        logic [11:0] black_threshold;
        logic [2:0]  trend_min_count;
        logic [2:0]  center_left_index;
        logic [2:0]  center_right_index;
        logic [3:0]  special_min_count;
    } t_cfg;

    // classified reading handed from front to back
    typedef struct packed {
        logic [3:0] black_total;
        logic [2:0] black_left;
        logic [2:0] black_right;
        logic [2:0] larger_side;
        logic       all_white;
        logic       center_line;
        logic       wide_line;
        logic       crossing;
        logic       special_eval;
        t_trend     cand_trend;
    } t_cls;

endpackage

// ===== design/lsta_front.sv =====
// Front stage: accept a reading, threshold and count sensors, register the classification.
module lsta_front import lsta_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_word i_data,
    input  t_cfg     i_cfg,
    output logic     o_cls_valid,
    input  logic     i_cls_ready,
    output t_cls     o_cls
);

    logic                   r_valid;
    logic                   n_valid;
    t_cls                   r_cls;
    t_cls                   n_cls;
    logic [SAMPLE_BITS-1:0] samples [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] black;
    logic [2:0]             left;
    logic [2:0]             right;
    logic                   accept;

    assign samples[0] = i_data.sample_0;
    assign samples[1] = i_data.sample_1;
    assign samples[2] = i_data.sample_2;
    assign samples[3] = i_data.sample_3;
    assign samples[4] = i_data.sample_4;
    assign samples[5] = i_data.sample_5;
    assign samples[6] = i_data.sample_6;
    assign samples[7] = i_data.sample_7;

    assign o_stall = r_valid && !i_cls_ready;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        for (int k = 0; k < SENSOR_COUNT; k++) begin
            black[k] = {{(16-SAMPLE_BITS){1'b0}}, samples[k]} >=
                       {4'd0, i_cfg.black_threshold};
        end
        left  = 3'd0;
        right = 3'd0;
        for (int k = 0; k < SIDE_COUNT; k++) begin
            left  = left + {2'd0, black[k]};
            right = right + {2'd0, black[k+SIDE_COUNT]};
        end
        n_cls.black_left   = left;
        n_cls.black_right  = right;
        n_cls.black_total  = {1'b0, left} + {1'b0, right};
        n_cls.larger_side  = (left > right) ? left : right;
        n_cls.all_white    = (n_cls.black_total == 4'd0);
        n_cls.center_line  = black[i_cfg.center_left_index] | black[i_cfg.center_right_index];
        n_cls.wide_line    = (n_cls.black_total >= 4'(WIDE_MIN));
        n_cls.crossing     = (n_cls.black_total >= 4'(CROSS_MIN));
        n_cls.special_eval = (n_cls.black_total >= i_cfg.special_min_count);
        if (left < i_cfg.trend_min_count && right < i_cfg.trend_min_count) begin
            n_cls.cand_trend = TREND_NONE;
        end else if (left > right) begin
            n_cls.cand_trend = TREND_LEFT;
        end else if (right > left) begin
            n_cls.cand_trend = TREND_RIGHT;
        end else begin
            n_cls.cand_trend = TREND_NONE;
        end
    end

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_cls_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cls <= n_cls;
        end
    end

    assign o_cls_valid = r_valid;
    assign o_cls       = r_cls;

endmodule

// ===== design/lsta_queue.sv =====
// Two-entry queue of classified words between front and back.
module lsta_queue import lsta_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cls i_cls,
    output logic o_valid,
    input  logic i_ready,
    output t_cls o_cls
);

    t_cls       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       push;
    logic       pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_cls   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        unique case ({push, pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cls;
        end
    end

endmodule

// ===== design/lsta_back.sv =====
// Back stage: advance the held trend and register the result word.
module lsta_back import lsta_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cls_valid,
    output logic      o_cls_ready,
    input  t_cls      i_cls,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data
);

    t_trend    r_held;
    t_trend    n_held;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_word r_out;
    t_out_word n_out;
    t_trend    trend_before;
    logic      take;

    assign o_cls_ready = !r_out_valid || !i_stall;
    assign take        = i_cls_valid && o_cls_ready;

    always_comb begin
        n_held = (i_cls.cand_trend != TREND_NONE) ? i_cls.cand_trend : r_held;
        if (!i_cls.special_eval) begin
            trend_before = TREND_NONE;
        end else if (r_held != TREND_NONE) begin
            trend_before = r_held;
        end else begin
            trend_before = n_held;
        end
        n_out.black_total       = i_cls.black_total;
        n_out.black_left        = i_cls.black_left;
        n_out.black_right       = i_cls.black_right;
        n_out.larger_side       = i_cls.larger_side;
        n_out.all_white         = i_cls.all_white;
        n_out.center_line       = i_cls.center_line;
        n_out.wide_line         = i_cls.wide_line;
        n_out.crossing          = i_cls.crossing;
        n_out.special_eval      = i_cls.special_eval;
        n_out.trend_before_eval = 2'(trend_before);
        n_out.trend_now         = 2'(n_held);
        n_out.trend_prior       = 2'(r_held);
        if (take) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= TREND_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (take) begin
                r_held <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== design/line_sensor_trend_analyzer.sv =====
// Top level of the line sensor trend analyzer: register file, front, queue and back.
// Path: an accepted word is registered in the front register, then in a queue entry and then in
// the output register; back-pressure from i_stall can hold it in any of these.
// Throughput: one word per cycle while i_stall is low; the front threshold/count stage and the back trend
// update each take one word a cycle.
// Reset (synchronous, active low): no trend held, queue and stages empty, registers at
// threshold 2048, trend minimum 1, center sensors 3 and 4, special minimum 4.
module line_sensor_trend_analyzer import lsta_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in_word             i_data,
    // output channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out_word            o_data,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    t_cfg       r_cfg;
    logic       cfg_write;
    logic [2:0] reg_index;

    t_cls       front_cls;
    logic       front_valid;
    logic       queue_ready;
    t_cls       queue_cls;
    logic       queue_valid;
    logic       back_ready;

    // Configuration registers: writes complete in the access phase; pready never waits.
    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.black_threshold    <= 12'd2048;
            r_cfg.trend_min_count    <= 3'd1;
            r_cfg.center_left_index  <= 3'd3;
            r_cfg.center_right_index <= 3'd4;
            r_cfg.special_min_count  <= 4'd4;
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_BLACK_THRESHOLD:    r_cfg.black_threshold    <= pwdata[11:0];
                REG_TREND_MIN_COUNT:    r_cfg.trend_min_count    <= pwdata[2:0];
                REG_CENTER_LEFT_INDEX:  r_cfg.center_left_index  <= pwdata[2:0];
                REG_CENTER_RIGHT_INDEX: r_cfg.center_right_index <= pwdata[2:0];
                REG_SPECIAL_MIN_COUNT:  r_cfg.special_min_count  <= pwdata[3:0];
                default: begin
                    // drop writes to unmapped addresses
                end
            endcase
        end
    end

    // Read back: unmapped addresses return zero.
    always_comb begin
        unique case (reg_index)
            REG_BLACK_THRESHOLD:    prdata = {20'd0, r_cfg.black_threshold};
            REG_TREND_MIN_COUNT:    prdata = {29'd0, r_cfg.trend_min_count};
            REG_CENTER_LEFT_INDEX:  prdata = {29'd0, r_cfg.center_left_index};
            REG_CENTER_RIGHT_INDEX: prdata = {29'd0, r_cfg.center_right_index};
            REG_SPECIAL_MIN_COUNT:  prdata = {28'd0, r_cfg.special_min_count};
            default:                prdata = '0;
        endcase
    end

    // Front: threshold the eight samples, count sides, derive flags and the candidate trend.
    lsta_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .i_cfg       (r_cfg),
        .o_cls_valid (front_valid),
        .i_cls_ready (queue_ready),
        .o_cls       (front_cls)
    );

    // Queue: decouple the front from output back-pressure.
    lsta_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (queue_ready),
        .i_cls   (front_cls),
        .o_valid (queue_valid),
        .i_ready (back_ready),
        .o_cls   (queue_cls)
    );

    // Back: hold the trend state and present the result word.
    lsta_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls_valid (queue_valid),
        .o_cls_ready (back_ready),
        .i_cls       (queue_cls),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

endmodule
